@@ rtl/cpbc_pkg.sv @@
// ============================================================================
// cpbc_pkg: shared types and constants of the camera pixel converter
// Pixel format codes, register indexes, queue entry layout, BT.601 chroma
// coefficients and the clamp helper.
// ============================================================================
package cpbc_pkg;

    typedef enum logic [1:0] {
        FMT_XBGR32 = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_YUYV   = 2'd3
    } pixel_format_t;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_index_t;

    localparam int unsigned DIM_WIDTH   = 13;
    localparam int unsigned CFG_WIDTH   = 13;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

    localparam logic [DIM_WIDTH-1:0] WIDTH_RESET  = 13'd1280;
    localparam logic [DIM_WIDTH-1:0] HEIGHT_RESET = 13'd720;
    localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

    // Chroma products: 18-bit coefficient times signed 8-bit offset chroma
    localparam int unsigned PROD_WIDTH = 26;
    localparam int unsigned TERM_WIDTH = PROD_WIDTH - 16;
    localparam logic signed [PROD_WIDTH-1:0] K_RV = 26'sd91881;
    localparam logic signed [PROD_WIDTH-1:0] K_GU = 26'sd22554;
    localparam logic signed [PROD_WIDTH-1:0] K_GV = 26'sd46802;
    localparam logic signed [PROD_WIDTH-1:0] K_BU = 26'sd116130;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   pair;
        pixel_t first;
        pixel_t second;
    } group_entry_t;

    // y + term, clamped to 0..255
    function automatic logic [7:0] clamp_sum(input logic [7:0] y,
                                             input logic signed [TERM_WIDTH-1:0] t);
        logic signed [TERM_WIDTH+1:0] s;
        logic [7:0]                   r;
        s = $signed({{(TERM_WIDTH-6){1'b0}}, y}) + $signed({{2{t[TERM_WIDTH-1]}}, t});
        if (s < 0)
            r = 8'd0;
        else if (s > $signed((TERM_WIDTH+2)'(255)))
            r = 8'hFF;
        else
            r = s[7:0];
        return r;
    endfunction

endpackage

@@ rtl/cpbc_if.sv @@
// ============================================================================
// cpbc channel interfaces
// Source-group channel and BGRA pixel channel, valid/ready handshake.
// ============================================================================
interface cpbc_group_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;

    modport source (output valid, byte_zero, byte_one, byte_two, byte_three,
                    input ready);
    modport sink (input valid, byte_zero, byte_one, byte_two, byte_three,
                  output ready);
endinterface

interface cpbc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       group_last;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, blue, green, red, alpha, group_last, row_end,
                    frame_end, input ready);
    modport sink (input valid, blue, green, red, alpha, group_last, row_end,
                  frame_end, output ready);
endinterface

@@ rtl/camera_pixel_to_bgra_converter_unit.sv @@
// ============================================================================
// camera_pixel_to_bgra_converter_unit: camera groups to opaque BGRA pixels
// XBGR32/BGR24/RGB24 pass-through with byte order fix-up, YUYV to two BT.601
// pixels, with row and frame end marking.
// ============================================================================
//
//  channel  | dir | word                                       | handshake
//  ---------+-----+--------------------------------------------+-----------
//  cam      | in  | byte_zero..byte_three (one source group)   | valid/ready
//  bgra     | out | blue, green, red, alpha, group/row/frame end | valid/ready
//  cfg      | in  | cfg_index, cfg_data                        | cfg_we only
//
//  Pass-through formats take one group per cycle while bgra.ready stays high.
//  Each pixel word leaves the output register at one per cycle while
//  bgra.ready is high, so a YUYV group gives up to two words, and once the
//  queue fills YUYV input is taken only as fast as those words leave. The
//  first pixel word of a group passes the front register, the queue and the
//  output register before it is presented.
//  Reset clears the handshake state, the queue and the column and row counts;
//  the format, width and height registers return to XBGR32, 1280 and 720.
//  A stall on bgra holds the output register; the four-entry queue and the
//  front register keep taking groups until they fill, then cam.ready drops.
//
module camera_pixel_to_bgra_converter_unit
    import cpbc_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cpbc_group_if.sink           cam,
    cpbc_pixel_if.source         bgra,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    pixel_format_t          format_reg, format_next;
    logic [DIM_WIDTH-1:0]   width_reg, width_next;
    logic [DIM_WIDTH-1:0]   height_reg, height_next;

    logic                   push_valid, push_ready;
    group_entry_t           push_data;
    logic                   head_valid, pop;
    group_entry_t           head;

    // Register writes; an index past the list is dropped
    always_comb
    begin
        format_next = format_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: format_next = pixel_format_t'(cfg_data[1:0]);
                REG_WIDTH:  width_next  = cfg_data[DIM_WIDTH-1:0];
                REG_HEIGHT: height_next = cfg_data[DIM_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_XBGR32;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            format_reg <= format_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Front: take a group, classify by format, form its pixels
    cpbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cam        (cam),
        .format     (format_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue: decouple the front from output stalls
    cpbc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_data   (head)
    );

    // Back: emit pixel words and track the row and frame position
    cpbc_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .bgra         (bgra)
    );

endmodule

@@ rtl/cpbc_front.sv @@
// ============================================================================
// cpbc_front: group intake and classification
// Registers each accepted group with its chroma products, then builds one or
// two candidate pixels and pushes them into the group queue.
// ============================================================================
module cpbc_front
    import cpbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cpbc_group_if.sink    cam,
    input  pixel_format_t format,
    output logic          push_valid,
    input  logic          push_ready,
    output group_entry_t  push_data
);

    logic                          s1_valid_reg, s1_valid_next;
    logic                          take;
    logic                          pair_reg;
    logic [7:0]                    y0_reg, y1_reg;
    pixel_t                        direct_reg, direct_next;
    logic signed [PROD_WIDTH-1:0]  rv_reg, gu_reg, gv_reg, bu_reg;
    logic signed [PROD_WIDTH-1:0]  u_ext, v_ext;
    logic signed [PROD_WIDTH-1:0]  g_sum;
    logic signed [TERM_WIDTH-1:0]  rc, gc_neg, bc;

    assign cam.ready = !s1_valid_reg || push_ready;
    assign take      = cam.valid && cam.ready;

    // Offset chroma: byte - 128 is the byte with its top bit flipped
    assign u_ext = $signed({{(PROD_WIDTH-7){~cam.byte_one[7]}}, cam.byte_one[6:0]});
    assign v_ext = $signed({{(PROD_WIDTH-7){~cam.byte_three[7]}}, cam.byte_three[6:0]});

    always_comb
    begin
        if (format == FMT_RGB24)
        begin
            direct_next.blue  = cam.byte_two;
            direct_next.green = cam.byte_one;
            direct_next.red   = cam.byte_zero;
        end
        else
        begin
            direct_next.blue  = cam.byte_zero;
            direct_next.green = cam.byte_one;
            direct_next.red   = cam.byte_two;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pair_reg   <= (format == FMT_YUYV);
            y0_reg     <= cam.byte_zero;
            y1_reg     <= cam.byte_two;
            direct_reg <= direct_next;
            rv_reg     <= K_RV * v_ext;
            gu_reg     <= K_GU * u_ext;
            gv_reg     <= K_GV * v_ext;
            bu_reg     <= K_BU * u_ext;
        end
    end

    // Arithmetic shift right by 16 is the floor division
    assign g_sum  = gu_reg + gv_reg;
    assign rc     = rv_reg[PROD_WIDTH-1:16];
    assign bc     = bu_reg[PROD_WIDTH-1:16];
    assign gc_neg = -$signed(g_sum[PROD_WIDTH-1:16]);

    always_comb
    begin
        push_data.pair = pair_reg;
        if (pair_reg)
        begin
            push_data.first.blue   = clamp_sum(y0_reg, bc);
            push_data.first.green  = clamp_sum(y0_reg, gc_neg);
            push_data.first.red    = clamp_sum(y0_reg, rc);
            push_data.second.blue  = clamp_sum(y1_reg, bc);
            push_data.second.green = clamp_sum(y1_reg, gc_neg);
            push_data.second.red   = clamp_sum(y1_reg, rc);
        end
        else
        begin
            push_data.first  = direct_reg;
            push_data.second = direct_reg;
        end
    end

    assign push_valid = s1_valid_reg;

endmodule

@@ rtl/cpbc_queue.sv @@
// ============================================================================
// cpbc_queue: short group queue
// Register FIFO between front and back; lets each side stall on its own.
// ============================================================================
module cpbc_queue
    import cpbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  group_entry_t push_data,
    output logic         pop_valid,
    input  logic         pop,
    output group_entry_t pop_data
);

    group_entry_t               entries [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QPTR_WIDTH:0]        count_reg, count_next;
    logic                       do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_WIDTH+1)'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH))
        || (wr_ptr_reg - rd_ptr_reg == count_reg[QPTR_WIDTH-1:0]))
        else $error("queue pointers disagree with count");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from an empty queue");

endmodule

@@ rtl/cpbc_back.sv @@
// ============================================================================
// cpbc_back: pixel emission and position tracking
// Emits one pixel word a cycle from the queue head unless bgra stalls, keeps
// row and column counts, drops the second YUYV pixel if the first ends a row.
// ============================================================================
module cpbc_back
    import cpbc_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DIM_WIDTH-1:0] image_width,
    input  logic [DIM_WIDTH-1:0] image_height,
    input  logic                 head_valid,
    input  group_entry_t         head,
    output logic                 pop,
    cpbc_pixel_if.source         bgra
);

    localparam int unsigned CW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

    function automatic logic [CW-1:0] last_index(input logic [DIM_WIDTH-1:0] d);
        logic [CW-1:0] r;
        if (d == '0)
            r = '0;
        else if ({1'b0, d} > (DIM_WIDTH+1)'(MAX_DIMENSION))
            r = CW'(MAX_DIMENSION - 1);
        else
            r = CW'(d - 1'b1);
        return r;
    endfunction

    logic [CW-1:0] col_last_reg, row_last_reg;
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic          phase_reg, phase_next;
    logic          out_valid_reg, out_valid_next;
    logic          load, row_done, last_row, group_done;
    pixel_t        pix_reg, pix_next;
    logic          group_last_reg, row_end_reg, frame_end_reg;

    assign load       = head_valid && (!out_valid_reg || bgra.ready);
    assign row_done   = (col_reg >= col_last_reg);
    assign last_row   = (row_reg >= row_last_reg);
    assign group_done = phase_reg || !head.pair || row_done;
    assign pop        = load && group_done;
    assign pix_next   = phase_reg ? head.second : head.first;

    always_comb
    begin
        phase_next     = phase_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = !group_done;
            if (row_done)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        else if (bgra.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg  <= '0;
            row_last_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_last_reg  <= last_index(image_width);
            row_last_reg  <= last_index(image_height);
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg        <= pix_next;
            group_last_reg <= group_done;
            row_end_reg    <= row_done;
            frame_end_reg  <= row_done && last_row;
        end
    end

    assign bgra.valid      = out_valid_reg;
    assign bgra.blue       = pix_reg.blue;
    assign bgra.green      = pix_reg.green;
    assign bgra.red        = pix_reg.red;
    assign bgra.alpha      = ALPHA_OPAQUE;
    assign bgra.group_last = group_last_reg;
    assign bgra.row_end    = row_end_reg;
    assign bgra.frame_end  = frame_end_reg;

    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> row_end_reg && group_last_reg)
        else $error("frame end without row end");

    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid && head.pair)
        else $error("second pixel pending without a pair group");

    a_row_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        load && row_done |=> col_reg == '0)
        else $error("column count did not wrap at row end");

endmodule

@@ tb/sv/camera_pixel_to_bgra_converter_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// camera_pixel_to_bgra_converter_unit_tb: self-checking bench for the converter
// Drives source groups and register writes, predicts every BGRA pixel word
// (pass-through formats, BT.601 YUYV, row and frame marking) and checks each
// word leaving the block against the oldest word owed. Both channels idle at
// random, with bursts of back-to-back traffic in between.
// ============================================================================
module camera_pixel_to_bgra_converter_unit_tb
    import cpbc_pkg::*;
();

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int MAX_DIM        = 4096;
    localparam int RESET_CYCLES   = 7;
    localparam int GAP_MAX        = 14;     // longest sender gap / receiver stall
    localparam int SETTLE_CYCLES  = 8;      // margin after the last owed word leaves
    localparam int IDLE_LIMIT     = 2000;   // cycles with no word moving at all
    localparam int RANDOM_ITEMS   = 1130;
    localparam int OWED_DEPTH     = 64;     // far above what the block can hold
    localparam int DIR_MAX        = 32;
    localparam int DIM_ALL_ONES   = (1 << CFG_WIDTH) - 1;

    // Unused register slot: writes to it must change nothing
    localparam logic [1:0] REG_SPARE = 2'd3;

    // BT.601 chroma terms in fixed point with 16 fraction bits
    localparam int K_RED_V    = 91881;
    localparam int K_GREEN_U  = 22554;
    localparam int K_GREEN_V  = 46802;
    localparam int K_BLUE_U   = 116130;
    localparam int CHROMA_MID = 128;
    localparam int FRAC_BITS  = 16;

    // One output pixel word as it leaves the block
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       group_last;
        logic       row_end;
        logic       frame_end;
    } bgra_word_t;

    // One row of the directed table: a register write or a source group.
    // A group row may carry up to two pixel words typed in by hand.
    typedef struct packed {
        logic                 is_reg_write;
        logic [1:0]           reg_sel;
        logic [CFG_WIDTH-1:0] reg_value;
        logic [7:0]           b0;
        logic [7:0]           b1;
        logic [7:0]           b2;
        logic [7:0]           b3;
        logic [1:0]           n_typed;
        bgra_word_t           typed0;
        bgra_word_t           typed1;
    } step_t;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    cpbc_group_if cam_ch ();
    cpbc_pixel_if bgra_ch ();

    camera_pixel_to_bgra_converter_unit #(
        .MAX_DIMENSION (MAX_DIM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam       (cam_ch),
        .bgra      (bgra_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the counters
    // ------------------------------------------------------------------------
    pixel_format_t        fmt_q;
    logic [CFG_WIDTH-1:0] width_q;
    logic [CFG_WIDTH-1:0] height_q;
    int                   col_cnt;
    int                   row_cnt;

    // Words produced by the latest group, and words still owed by the block
    bgra_word_t calc_px [2];
    int         calc_n;
    bgra_word_t owed_words [OWED_DEPTH];
    int         owed_head;
    int         owed_tail;

    // Directed table rows
    step_t dir_rows [DIR_MAX];
    int    dir_count;

    int error_count;
    int word_count;
    bit send_burst;     // sender runs without gaps
    bit sink_burst;     // receiver never stalls

    function automatic bgra_word_t word(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       logic gl, logic re, logic fe);
        bgra_word_t w;
        w = '{blue: b, green: g, red: r, alpha: 8'hFF,
              group_last: gl, row_end: re, frame_end: fe};
        return w;
    endfunction

    // Append one word to the ring of words still owed
    function automatic void owe_word(bgra_word_t w);
        owed_words[owed_tail % OWED_DEPTH] = w;
        owed_tail++;
    endfunction

    function automatic int owed_count();
        return owed_tail - owed_head;
    endfunction

    function automatic void add_row(step_t s);
        dir_rows[dir_count] = s;
        dir_count++;
    endfunction

    // Zero counts as one, anything past the maximum saturates
    function automatic int eff_dim(logic [CFG_WIDTH-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    function automatic logic [7:0] sat_byte(int x);
        if (x < 0)
            return 8'd0;
        if (x > 255)
            return 8'hFF;
        return x[7:0];
    endfunction

    // Emit one pixel and advance the counters. A column at or past the last
    // column ends the row; a row at or past the last row ends the frame.
    // Returns whether this pixel closed a row.
    function automatic bit place_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       bit closes_group);
        int w;
        int h;
        bit rend;
        bit lastrow;
        w       = eff_dim(width_q);
        h       = eff_dim(height_q);
        rend    = (col_cnt >= w - 1);
        lastrow = (row_cnt >= h - 1);
        calc_px[calc_n] = word(b, g, r, closes_group | rend, rend, rend & lastrow);
        calc_n++;
        if (rend)
        begin
            col_cnt = 0;
            row_cnt = lastrow ? 0 : row_cnt + 1;
        end
        else
            col_cnt++;
        return rend;
    endfunction

    // Work out the pixel words one source group produces
    function automatic void predict_group(logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3);
        int u;
        int v;
        int rc;
        int gc;
        int bc;
        int y0;
        int y1;
        calc_n = 0;
        unique case (fmt_q)
            FMT_RGB24:
                void'(place_pixel(b2, b1, b0, 1'b1));
            FMT_YUYV:
            begin
                y0 = int'(b0);
                y1 = int'(b2);
                u  = int'(b1) - CHROMA_MID;
                v  = int'(b3) - CHROMA_MID;
                // arithmetic shift on a signed int floors toward minus infinity
                rc = (K_RED_V * v) >>> FRAC_BITS;
                gc = (K_GREEN_U * u + K_GREEN_V * v) >>> FRAC_BITS;
                bc = (K_BLUE_U * u) >>> FRAC_BITS;
                // drop the second pixel when the first one closes the row
                if (!place_pixel(sat_byte(y0 + bc), sat_byte(y0 - gc),
                                 sat_byte(y0 + rc), 1'b0))
                    void'(place_pixel(sat_byte(y1 + bc), sat_byte(y1 - gc),
                                      sat_byte(y1 + rc), 1'b1));
            end
            default:    // XBGR32 and BGR24 keep the order, fourth byte unused
                void'(place_pixel(b0, b1, b2, 1'b1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic flag_error(string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("pixel word %0d: %s is %h, predicted %h",
                                 word_count, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic step_t reg_step(logic [1:0] sel, logic [CFG_WIDTH-1:0] value);
        step_t s;
        s              = '0;
        s.is_reg_write = 1'b1;
        s.reg_sel      = sel;
        s.reg_value    = value;
        return s;
    endfunction

    function automatic step_t group_step(logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3,
                                         logic [1:0] n_typed,
                                         bgra_word_t t0, bgra_word_t t1);
        step_t s;
        s         = '0;
        s.b0      = b0;
        s.b1      = b1;
        s.b2      = b2;
        s.b3      = b3;
        s.n_typed = n_typed;
        s.typed0  = t0;
        s.typed1  = t1;
        return s;
    endfunction

    // Bias toward the byte extremes so the YUYV clamps fire often
    function automatic logic [7:0] pick_byte();
        unique case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly tiny frames so rows and frames close often, now and then the
    // degenerate and oversized values
    function automatic logic [CFG_WIDTH-1:0] pick_dim(int small_max);
        unique case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_WIDTH'(MAX_DIM);
            2:       return CFG_WIDTH'($urandom_range(MAX_DIM + 1, DIM_ALL_ONES));
            3:       return CFG_WIDTH'($urandom_range(9, 200));
            default: return CFG_WIDTH'($urandom_range(1, small_max));
        endcase
    endfunction

    // Write one register with a single-cycle pulse on cfg_we, and return only after
    // cfg_we has been sampled low, so back-to-back writes stay separate pulses.
    task automatic write_reg(logic [1:0] sel, logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        unique case (sel)
            REG_FORMAT: fmt_q    = pixel_format_t'(value[1:0]);
            REG_WIDTH:  width_q  = value;
            REG_HEIGHT: height_q = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, wait until every predicted word is out, then let the
    // pipeline settle so nothing is in flight
    task automatic wait_pixels_drained();
        cam_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one source group, wait for the handshake, then queue its words.
    // Valid stays high across back-to-back words and only drops for a gap.
    task automatic send_group(logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3,
                              logic [1:0] n_typed, bgra_word_t t0, bgra_word_t t1);
        int gap;
        int k;
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            cam_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cam_ch.valid      <= 1'b1;
        cam_ch.byte_zero  <= b0;
        cam_ch.byte_one   <= b1;
        cam_ch.byte_two   <= b2;
        cam_ch.byte_three <= b3;
        do
            @(posedge clk);
        while (cam_ch.ready !== 1'b1);
        predict_group(b0, b1, b2, b3);
        // hand-typed words win; the predictor still advances its counters
        if (n_typed != 2'd0)
        begin
            owe_word(t0);
            if (n_typed == 2'd2)
                owe_word(t1);
        end
        else
            for (k = 0; k < calc_n; k++)
                owe_word(calc_px[k]);
    endtask

    // ------------------------------------------------------------------------
    // Pixel receiver: random stalls, compare each word with the oldest one owed
    // ------------------------------------------------------------------------
    initial
    begin : pixel_sink
        int         stall;
        bgra_word_t got;
        bgra_word_t want;
        bgra_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                bgra_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            bgra_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (bgra_ch.valid !== 1'b1);
            got = '{blue: bgra_ch.blue, green: bgra_ch.green, red: bgra_ch.red,
                    alpha: bgra_ch.alpha, group_last: bgra_ch.group_last,
                    row_end: bgra_ch.row_end, frame_end: bgra_ch.frame_end};
            if (owed_count() == 0)
                flag_error($sformatf("pixel word %0d arrived with nothing pending",
                                     word_count));
            else
            begin
                want = owed_words[owed_head % OWED_DEPTH];
                owed_head++;
                check_field("blue",       got.blue,       want.blue);
                check_field("green",      got.green,      want.green);
                check_field("red",        got.red,        want.red);
                check_field("alpha",      got.alpha,      want.alpha);
                check_field("group_last", 8'(got.group_last), 8'(want.group_last));
                check_field("row_end",    8'(got.row_end),    8'(want.row_end));
                check_field("frame_end",  8'(got.frame_end),  8'(want.frame_end));
            end
            word_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cam_ch.valid === 1'b1 && cam_ch.ready === 1'b1) ||
                (bgra_ch.valid === 1'b1 && bgra_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] timeout: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("camera_pixel_to_bgra_converter_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, verdict
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        step_t s;
        int    sent;
        int    n_phase;
        int    i;

        // drive every input to a known value from time zero
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_FORMAT;
        cfg_data          <= '0;
        cam_ch.valid      <= 1'b0;
        cam_ch.byte_zero  <= 8'h00;
        cam_ch.byte_one   <= 8'h00;
        cam_ch.byte_two   <= 8'h00;
        cam_ch.byte_three <= 8'h00;

        // predictor copy of the reset state: XBGR32, 1280 x 720, counters clear
        fmt_q       = FMT_XBGR32;
        width_q     = CFG_WIDTH'(1280);
        height_q    = CFG_WIDTH'(720);
        col_cnt     = 0;
        row_cnt     = 0;
        owed_head   = 0;
        owed_tail   = 0;
        dir_count   = 0;
        error_count = 0;
        word_count  = 0;
        send_burst  = 1'b0;
        sink_burst  = 1'b0;

        // Directed table. Typed words follow the counters by hand: the first
        // few land mid-row of the reset 1280-wide frame.
        // reset format passes B,G,R through, pad byte ignored
        add_row(group_step(8'h00, 8'hFF, 8'h00, 8'hFF, 2'd1,
                           word(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0), '0));
        add_row(group_step(8'hFF, 8'h00, 8'hFF, 8'h00, 2'd1,
                           word(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0), '0));
        // out-of-range register index must be ignored
        add_row(reg_step(REG_SPARE, CFG_WIDTH'(DIM_ALL_ONES)));
        add_row(reg_step(REG_FORMAT, CFG_WIDTH'(FMT_BGR24)));
        add_row(group_step(8'h12, 8'h34, 8'h56, 8'h78, 2'd1,
                           word(8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 1'b0), '0));
        // RGB24 swaps first and third bytes
        add_row(reg_step(REG_FORMAT, CFG_WIDTH'(FMT_RGB24)));
        add_row(group_step(8'h12, 8'h34, 8'h56, 8'h78, 2'd1,
                           word(8'h56, 8'h34, 8'h12, 1'b1, 1'b0, 1'b0), '0));
        // zero width acts as one; column already past the end closes the row
        add_row(reg_step(REG_WIDTH, '0));
        add_row(group_step(8'hAA, 8'hBB, 8'hCC, 8'hDD, 2'd1,
                           word(8'hCC, 8'hBB, 8'hAA, 1'b1, 1'b1, 1'b0), '0));
        // zero height acts as one; row already past the end closes the frame
        add_row(reg_step(REG_HEIGHT, '0));
        add_row(group_step(8'h01, 8'h02, 8'h03, 8'h04, 2'd1,
                           word(8'h03, 8'h02, 8'h01, 1'b1, 1'b1, 1'b1), '0));
        // YUYV at odd width: neutral chroma, second pixel dropped at row end
        add_row(reg_step(REG_FORMAT, CFG_WIDTH'(FMT_YUYV)));
        add_row(group_step(8'h10, 8'h80, 8'hEB, 8'h80, 2'd1,
                           word(8'h10, 8'h10, 8'h10, 1'b1, 1'b1, 1'b1), '0));
        // 2 x 2 frame: a full macropixel per row, luma extremes
        add_row(reg_step(REG_WIDTH, CFG_WIDTH'(2)));
        add_row(reg_step(REG_HEIGHT, CFG_WIDTH'(2)));
        add_row(group_step(8'h00, 8'h80, 8'hFF, 8'h80, 2'd2,
                           word(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0),
                           word(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0)));
        // chroma extremes: both clamps
        add_row(group_step(8'h80, 8'h00, 8'h80, 8'h00, 2'd0, '0, '0));
        add_row(group_step(8'h80, 8'hFF, 8'h80, 8'hFF, 2'd0, '0, '0));
        // oversized dimensions saturate
        add_row(reg_step(REG_WIDTH, CFG_WIDTH'(DIM_ALL_ONES)));
        add_row(reg_step(REG_HEIGHT, CFG_WIDTH'(DIM_ALL_ONES)));
        add_row(group_step(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd0, '0, '0));
        add_row(group_step(8'h00, 8'h00, 8'h00, 8'h00, 2'd0, '0, '0));
        // odd width of three: a macropixel that reaches the row end loses its second pixel
        add_row(reg_step(REG_WIDTH, CFG_WIDTH'(3)));
        add_row(reg_step(REG_HEIGHT, CFG_WIDTH'(3)));
        add_row(group_step(8'hEB, 8'h00, 8'h10, 8'hFF, 2'd0, '0, '0));
        add_row(group_step(8'h10, 8'hFF, 8'hEB, 8'h00, 2'd0, '0, '0));
        add_row(group_step(8'hFF, 8'h80, 8'h00, 8'h80, 2'd0, '0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table; drain before every register write
        for (i = 0; i < dir_count; i++)
        begin
            s = dir_rows[i];
            if (s.is_reg_write)
            begin
                wait_pixels_drained();
                write_reg(s.reg_sel, s.reg_value);
            end
            else
                send_group(s.b0, s.b1, s.b2, s.b3, s.n_typed, s.typed0, s.typed1);
        end

        // Random phases: a random format each time, often new dimensions, random groups in between.
        // Counters carry over, so shrinking the frame exercises the
        // past-the-end wrap as well.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_pixels_drained();
            write_reg(REG_FORMAT, CFG_WIDTH'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WIDTH, pick_dim(8));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_HEIGHT, pick_dim(4));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, CFG_WIDTH'($urandom_range(0, DIM_ALL_ONES)));
            send_burst = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            n_phase    = $urandom_range(20, 80);
            for (i = 0; i < n_phase; i++)
            begin
                // now and then hold the sender until the block is empty
                if ($urandom_range(0, 39) == 0)
                    wait_pixels_drained();
                send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           2'd0, '0, '0);
                sent++;
            end
        end

        // let the last words out, then wait out the settle time for strays
        wait_pixels_drained();
        if (error_count == 0)
            $display("camera_pixel_to_bgra_converter_unit verification clean");
        else
            $display("camera_pixel_to_bgra_converter_unit verification failed");
        $finish;
    end

endmodule

@@ camera_pixel_to_bgra_converter_unit.f @@
rtl/cpbc_pkg.sv
rtl/cpbc_if.sv
rtl/cpbc_front.sv
rtl/cpbc_queue.sv
rtl/cpbc_back.sv
rtl/camera_pixel_to_bgra_converter_unit.sv
tb/sv/camera_pixel_to_bgra_converter_unit_tb.sv
